[rtl/angular_correlation_cos_sampler_top_macros.svh]
// assertion macros shared by the sampler modules
`ifndef ANGULAR_CORRELATION_COS_SAMPLER_TOP_MACROS_SVH
`define ANGULAR_CORRELATION_COS_SAMPLER_TOP_MACROS_SVH
// a condition implies a consequence in the same cycle
`define ACS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// a condition implies a consequence in the next cycle
`define ACS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

[rtl/acs_pkg.sv]
// shared types and constants of the cos sampler
`default_nettype none
package acs_pkg;
    localparam int unsigned TableEntries = 1025;

    // controller commands to the datapath
    typedef struct packed {
        logic load;       // capture sample, init search
        logic eval_start; // start cumulative at eval_idx
        logic [1:0] eval_sel; // 0 mid-1, 1 left, 2 right
        logic step;       // apply bisection decision
        logic div_start;  // start interpolation divide
        logic finish;     // form result
    } t_acs_cmd;

    localparam logic [1:0] SelMid   = 2'd0;
    localparam logic [1:0] SelLeft  = 2'd1;
    localparam logic [1:0] SelRight = 2'd2;

    // datapath status to the controller
    typedef struct packed {
        logic eval_done;
        logic search_done;
        logic div_done;
        logic flat;
    } t_acs_sts;
endpackage
`default_nettype wire

[rtl/angular_correlation_cos_sampler_top.sv]
// top level of the angular correlation cos sampler
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: uniform_sample[15:0]
//  m_axis    out  tdata: cos_angle[15:0]; tuser: flat_bracket
//  cfg       in   index 0 p2_weight, 1 p4_weight
// one item at a time: 10 or 11 search steps (each an issue state plus a
// nine-phase cumulative evaluation on a shared 32x32 multiplier), then the
// left and right bracket evaluations, the one-bit-a-step divider (skipped on
// a flat bracket), then one state to form the result and one to hand it out.
// synchronous reset clears weights and control; no clearing pass.
// the result waits in its register while the output stalls; input not ready until taken.
`default_nettype none
module angular_correlation_cos_sampler_top #(
    parameter int unsigned TABLE_ENTRIES = acs_pkg::TableEntries
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // uniform_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // cos_angle
    output logic             m_axis_tuser,  // flat_bracket
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import acs_pkg::*;

    t_acs_cmd w_cmd;
    t_acs_sts w_sts;
    logic signed [15:0] r_p2_weight, r_p4_weight, w_cos;

    // weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_weight <= '0;
            r_p4_weight <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index) r_p4_weight <= i_cfg_data;
            else r_p2_weight <= i_cfg_data;
        end
    end

    acs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_fire(m_axis_tvalid && m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    acs_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_p2_weight(r_p2_weight), .i_p4_weight(r_p4_weight),
        .i_sample(s_axis_tdata), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_cos_angle(w_cos), .o_flat_bracket(m_axis_tuser)
    );
    assign m_axis_tdata = w_cos;
endmodule
`default_nettype wire

[rtl/acs_datapath.sv]
// search, cumulative evaluation and interpolation datapath
`default_nettype none
module acs_datapath #(
    parameter int unsigned TABLE_ENTRIES = acs_pkg::TableEntries
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic signed [15:0] i_p2_weight,
    input  wire logic signed [15:0] i_p4_weight,
    input  wire logic [15:0]      i_sample,
    input  wire acs_pkg::t_acs_cmd i_cmd,
    output acs_pkg::t_acs_sts     o_sts,
    output logic signed [15:0]    o_cos_angle,
    output logic                  o_flat_bracket
);
    import acs_pkg::*;

    localparam int unsigned Knots = (TABLE_ENTRIES < 3) ? 3 :
                                    ((TABLE_ENTRIES > 4097) ? 4097 : TABLE_ENTRIES);
    localparam int unsigned Iw = $clog2(Knots + 2);
    localparam logic [63:0] Span = 64'(Knots - 1);
    // knot position i*2^31/span as i*q plus an exact reciprocal divide of the rest
    localparam int unsigned SpanLog = $clog2(Knots - 1);
    localparam int unsigned Nk = 25;
    localparam int unsigned KnotSh = Nk + SpanLog;
    localparam logic [63:0] KnotQ = (64'd1 << 31) / Span;
    localparam logic [63:0] KnotR = (64'd1 << 31) % Span;
    localparam logic [63:0] KnotM = ((64'd1 << KnotSh) + Span - 64'd1) / Span;

    // search bounds and captured operands
    logic [Iw-1:0] r_lo, r_hi, n_lo, n_hi;
    logic signed [31:0] r_y;
    logic signed [31:0] r_c0, r_c1, r_x0, r_x1;
    logic [Iw-1:0] w_mid, w_idx;
    logic [Iw:0]   w_sum;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[Iw:1];

    // clamped bracket index
    always_comb begin
        if (r_lo == '0) begin
            w_idx = '0;
        end else if ({1'b0, r_lo} - 1'b1 > Iw'(Knots - 2)) begin
            w_idx = Iw'(Knots - 2);
        end else begin
            w_idx = r_lo - 1'b1;
        end
    end

    // multicycle cumulative evaluation sequencer
    logic [3:0]  r_ph;
    logic        r_busy;
    logic [1:0]  r_sel;
    logic        r_neg;
    logic [31:0] r_kb;
    logic [Nk-1:0] r_kn;
    logic [51:0] w_kprod;
    logic [31:0] w_kq;
    logic signed [31:0] r_x;
    logic [31:0] r_m, r_m2, r_m3, r_m5;
    logic signed [63:0] r_t;
    logic [63:0] w_prod;
    logic [31:0] w_ma, w_mb;
    logic [Iw-1:0] w_eidx;
    logic signed [34:0] w_x3, w_x5;
    logic signed [38:0] w_s4;
    logic signed [34:0] w_s2;
    logic signed [31:0] w_c;

    always_comb begin
        unique case (r_sel)
            SelLeft:  w_eidx = w_idx;
            SelRight: w_eidx = w_idx + 1'b1;
            default:  w_eidx = w_mid - 1'b1;
        endcase
    end

    // rounded quotient of the small remainder part of the knot position
    assign w_kprod = 52'(r_kn) * 52'(KnotM);
    assign w_kq    = 32'(w_kprod >> KnotSh);

    // one shared 32x32 multiplier
    always_comb begin
        case (r_ph)
            4'd3:    begin w_ma = r_m;  w_mb = r_m;  end
            4'd4:    begin w_ma = r_m2; w_mb = r_m;  end
            default: begin w_ma = r_m3; w_mb = r_m2; end
        endcase
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    assign w_x3 = r_neg ? -35'(r_m3) : 35'(r_m3);
    assign w_x5 = r_neg ? -35'(r_m5) : 35'(r_m5);
    assign w_s2 = w_x3 - 35'(r_x);
    assign w_s4 = 39'(w_x5) * 39'sd7 - 39'(w_x3) * 39'sd10 + 39'(r_x) * 39'sd3;
    assign w_c  = 32'(r_t >>> 18);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= '0;
        end else if (i_cmd.eval_start) begin
            r_busy <= 1'b1;
            r_ph   <= 4'd0;
            r_sel  <= i_cmd.eval_sel;
        end else if (r_busy) begin
            r_ph <= r_ph + 1'b1;
            case (r_ph)
                4'd0: begin
                    r_kb <= 32'(w_eidx) * 32'(KnotQ);
                    r_kn <= Nk'(w_eidx) * Nk'(KnotR) + Nk'(Span >> 1);
                end
                4'd1: r_x <= $signed(r_kb + w_kq - 32'h4000_0000);
                4'd2: begin
                    r_neg <= r_x[31];
                    r_m   <= r_x[31] ? 32'(-r_x) : 32'(r_x);
                end
                4'd3: r_m2 <= 32'(w_prod >> 30);
                4'd4: r_m3 <= 32'(w_prod >> 30);
                4'd5: r_m5 <= 32'(w_prod >> 30);
                4'd6: r_t <= ((64'sh4000_0000 + 64'(r_x)) <<< 17)
                            + 64'(w_s2) * 64'(i_p2_weight) * 64'sd4;
                4'd7: r_t <= r_t + 64'(w_s4) * 64'(i_p4_weight);
                default: r_busy <= 1'b0;
            endcase
        end
    end
    assign o_sts.eval_done = r_busy && (r_ph == 4'd8);

    // search bounds
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = Iw'(Knots + 1);
        end else if (i_cmd.step) begin
            if ($signed({1'b0, r_y}) > $signed({w_c[31], w_c})) n_lo = w_mid;
            else n_hi = w_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd.load) r_y <= {2'b0, i_sample, 14'b0};
        if (o_sts.eval_done && r_sel == SelLeft) begin
            r_c0 <= w_c;
            r_x0 <= r_x;
        end
        if (o_sts.eval_done && r_sel == SelRight) begin
            r_c1 <= w_c;
            r_x1 <= r_x;
        end
    end
    assign o_sts.search_done = (r_hi - r_lo) <= Iw'(1);

    // restoring divider on magnitudes, numerator wide enough for the knot step
    localparam int unsigned Dw = $clog2(KnotQ + 64'd2);
    localparam int unsigned Nw = 34 + Dw;
    localparam int unsigned Cw = $clog2(Nw + 1);
    localparam int unsigned Rw = Nw + 2;
    logic [Nw-1:0] r_q, r_rem_n;
    logic [33:0]   r_den;
    logic [34:0]   r_rem;
    logic [Cw-1:0] r_cnt;
    logic          r_dbusy, r_qneg;
    logic signed [33:0] w_dy, w_d, w_dx;
    logic signed [Nw-1:0] w_num;
    logic [34:0] w_trial;

    assign w_dy  = 34'(r_y) - 34'(r_c0);
    assign w_d   = 34'(r_c1) - 34'(r_c0);
    assign w_dx  = 34'(r_x1) - 34'(r_x0);
    assign w_num = Nw'(w_dy) * Nw'(w_dx);
    assign o_sts.flat = (w_d == '0);
    assign w_trial = {r_rem[33:0], r_rem_n[Nw-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_cnt   <= Cw'(Nw);
            r_rem   <= '0;
            r_rem_n <= w_num[Nw-1] ? Nw'(-w_num) : Nw'(w_num);
            r_den   <= w_d[33] ? 34'(-w_d) : 34'(w_d);
            r_qneg  <= w_num[Nw-1] ^ w_d[33];
        end else if (r_dbusy && r_cnt != '0) begin
            r_cnt   <= r_cnt - 1'b1;
            r_rem_n <= r_rem_n << 1;
            if (!w_trial[34]) begin
                r_rem <= w_trial;
                r_q   <= {r_q[Nw-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[33:0], r_rem_n[Nw-1]};
                r_q   <= {r_q[Nw-2:0], 1'b0};
            end
        end else if (r_dbusy) begin
            r_dbusy <= 1'b0;
        end
    end
    assign o_sts.div_done = r_dbusy && (r_cnt == '0);

    // rounding and saturation
    logic signed [Rw-1:0] w_r, w_rr;
    always_comb begin
        if (o_sts.flat) w_r = Rw'(r_x0);
        else w_r = Rw'(r_x0) + (r_qneg ? -Rw'(r_q) : Rw'(r_q));
        w_rr = (w_r + Rw'(16384)) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_flat_bracket <= o_sts.flat;
            if (w_rr > Rw'(32767)) o_cos_angle <= 16'sh7fff;
            else if (w_rr < -Rw'(32768)) o_cos_angle <= 16'sh8000;
            else o_cos_angle <= 16'(w_rr);
        end
    end

    `include "angular_correlation_cos_sampler_top_macros.svh"
    `ACS_ASSERT_IMP(a_bounds_order, i_clk, i_rst_n, !i_cmd.load && r_hi != '0, r_lo < r_hi)
    `ACS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, r_dbusy, !r_busy)
    `ACS_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, o_sts.div_done, !r_dbusy)
endmodule
`default_nettype wire

[rtl/acs_ctrl.sv]
// sequencing state machine of the sampler
`default_nettype none
module acs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_fire,
    input  wire logic              i_out_fire,
    input  wire acs_pkg::t_acs_sts i_sts,
    output acs_pkg::t_acs_cmd      o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);
    import acs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRCH  = 8'b0000_0010,
        S_SWAIT = 8'b0000_0100,
        S_LEFT  = 8'b0000_1000,
        S_RIGHT = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_started, n_started;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_started = r_started;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (i_in_fire) begin
                o_cmd.load = 1'b1;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if (i_sts.search_done) begin
                    o_cmd.eval_start = 1'b1;
                    o_cmd.eval_sel = SelLeft;
                    n_started = 1'b0;
                    n_state = S_LEFT;
                end else begin
                    o_cmd.eval_start = 1'b1;
                    o_cmd.eval_sel = SelMid;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: if (i_sts.eval_done) begin
                o_cmd.step = 1'b1;
                n_state = S_SRCH;
            end
            S_LEFT: if (i_sts.eval_done) begin
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel = SelRight;
                n_state = S_RIGHT;
            end
            S_RIGHT: if (i_sts.eval_done) begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!r_started) begin
                    if (i_sts.flat) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_started = 1'b1;
                    end
                end else if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `include "angular_correlation_cos_sampler_top_macros.svh"
    `ACS_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, 1'b1, !(o_in_ready && o_out_valid))
    `ACS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_fire, r_state == S_SRCH)
    `ACS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && !i_out_fire, o_out_valid)
endmodule
`default_nettype wire

[sim/angular_correlation_cos_sampler_top_tb.sv]
// self-checking testbench of the angular correlation cos sampler
`default_nettype none
module angular_correlation_cos_sampler_top_tb;
    localparam int unsigned KNOTS = acs_pkg::TableEntries;
    localparam logic CfgP2 = 1'b0;
    localparam logic CfgP4 = 1'b1;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned RANDOM_PER_PHASE = 190;

    typedef struct packed {
        logic [15:0] cos_angle;
        logic        flat_bracket;
    } t_sample_out;

    // directed row: input, whether the result is typed in, and that result
    typedef struct {
        logic [15:0] uniform_sample;
        bit          known;
        t_sample_out result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;  // uniform_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;  // cos_angle
    logic        m_axis_tuser;  // flat_bracket
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    logic signed [15:0] p2_weight;
    logic signed [15:0] p4_weight;
    t_sample_out        pending_samples[$];
    bit                 failed;
    bit                 rx_stall_on;
    int unsigned        cycle_count;

    angular_correlation_cos_sampler_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor division by a power of two
    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    // knot position in q1.30
    function automatic longint knot_pos(longint i);
        longint span;
        span = KNOTS - 1;
        return (i * (64'sd1 << 31) + span / 2) / span - ONE_Q30;
    endfunction

    // cumulative distribution at a knot in q30
    function automatic longint cdf_at(longint i);
        longint x, m, m2, m3, m5, x3, x5, s2, s4, t;
        x = knot_pos(i);
        m = (x < 0) ? -x : x;
        m2 = (m * m) >>> 30;
        m3 = (m2 * m) >>> 30;
        m5 = (m3 * m2) >>> 30;
        x3 = (x < 0) ? -m3 : m3;
        x5 = (x < 0) ? -m5 : m5;
        s2 = x3 - x;
        s4 = 7 * x5 - 10 * x3 + 3 * x;
        t = (ONE_Q30 + x) * (64'sd1 << 17) + 4 * longint'(p2_weight) * s2
            + longint'(p4_weight) * s4;
        return floor_div_pow2(t, 18);
    endfunction

    // inverse cdf lookup with linear interpolation
    function automatic t_sample_out sample_cos(logic [15:0] u);
        longint y, lo, hi, mid, idx, x0, x1, c0, c1, d, r, c;
        t_sample_out res;
        y = longint'(u) << 14;
        lo = 0;
        hi = KNOTS + 1;
        res.flat_bracket = 1'b0;
        while (hi - lo > 1) begin
            mid = (hi + lo) / 2;
            if (y > cdf_at(mid - 1)) lo = mid;
            else hi = mid;
        end
        idx = lo - 1;
        if (idx < 0) idx = 0;
        if (idx > KNOTS - 2) idx = KNOTS - 2;
        x0 = knot_pos(idx);
        x1 = knot_pos(idx + 1);
        c0 = cdf_at(idx);
        c1 = cdf_at(idx + 1);
        d = c1 - c0;
        if (d == 0) begin
            r = x0;
            res.flat_bracket = 1'b1;
        end else begin
            r = x0 + ((y - c0) * (x1 - x0)) / d;
        end
        c = floor_div_pow2(r + (64'sd1 << 14), 15);
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        res.cos_angle = c[15:0];
        return res;
    endfunction

    task automatic write_weight(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgP2) p2_weight = value;
        else p4_weight = value;
    endtask

    // one transfer on the input side, optionally preceded by a gap
    task automatic send_sample(logic [15:0] u, bit gaps, bit known, t_sample_out res);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= u;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_samples.push_back(known ? res : sample_cos(u));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // random sample: mostly uniform, some edges of the range
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom_range(65520, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 16384));
            3: return 16'(-$urandom_range(0, 16384));
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stall bursts, sampled at the rising edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!rx_stall_on) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_sample_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result cos_angle=%0h", m_axis_tdata);
                failed <= 1'b1;
            end else begin
                want = pending_samples.pop_front();
                if (m_axis_tdata !== want.cos_angle) begin
                    $error("cos_angle expected %0h actual %0h", want.cos_angle, m_axis_tdata);
                    failed <= 1'b1;
                end
                if (m_axis_tuser !== want.flat_bracket) begin
                    $error("flat_bracket expected %0b actual %0b",
                           want.flat_bracket, m_axis_tuser);
                    failed <= 1'b1;
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        logic [15:0] directed_inputs[] = '{16'h0000, 16'hffff, 16'h8000, 16'h0001,
            16'hfffe, 16'h7fff, 16'h4000, 16'hc000, 16'h5555, 16'haaaa, 16'h00ff,
            16'hff00, 16'h1234};
        failed = 1'b0;
        cycle_count = 0;
        rx_stall_on = 1'b1;
        p2_weight = '0;
        p4_weight = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CfgP2;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows with default weights: y=0 gives -1, y=1/2 gives 0
        row = '{16'h0000, 1'b1, '{16'h8000, 1'b0}};
        rows.push_back(row);
        row = '{16'h8000, 1'b1, '{16'h0000, 1'b0}};
        rows.push_back(row);
        foreach (directed_inputs[k]) begin
            row = '{directed_inputs[k], 1'b0, '{16'h0, 1'b0}};
            rows.push_back(row);
        end
        foreach (rows[k]) send_sample(rows[k].uniform_sample, 1'b0, rows[k].known,
                                      rows[k].result);
        // sender holds off until everything came back
        drain_results();

        // extreme weights, directed edges each
        for (int ph = 0; ph < 4; ph++) begin
            write_weight(CfgP2, ph[0] ? 16'h7fff : 16'h8000);
            write_weight(CfgP4, ph[1] ? 16'h7fff : 16'h8000);
            foreach (directed_inputs[k]) send_sample(directed_inputs[k], 1'b1, 1'b0, '0);
            drain_results();
        end

        // random phases, several weight settings, last phase without idling
        for (int ph = 0; ph < 6; ph++) begin
            write_weight(CfgP2, rand_weight());
            write_weight(CfgP4, rand_weight());
            if (ph == 5) rx_stall_on = 1'b0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_sample(rand_sample(), ph != 5, 1'b0, '0);
            drain_results();
        end

        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
